// File: src/prrs_pkg.sv
// shared types, constants and codes for the priority round robin scheduler
`timescale 1ns / 1ps
package prrs_pkg;

	localparam int MAX_THREADS_DEF = 16;
	localparam int NUM_LEVELS_DEF  = 32;
	localparam int NUM_CPUS_DEF    = 4;
	localparam int SPACE_BITS_DEF  = 16;

	localparam logic [7:0] SLICE_RESET = 8'd5;

	localparam int OP_W     = 2;
	localparam int PRIO_W   = 5;
	localparam int CPU_W    = 2;
	localparam int TID_W    = 4;
	localparam int STATUS_W = 3;
	localparam int SPACE_W  = 16;
	localparam int SLICE_W  = 8;

	localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
	localparam logic [OP_W-1:0] OP_RESCHED = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK = 2'd2;

	localparam logic [STATUS_W-1:0] ST_CREATED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_SWITCHED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_STAYED   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_COUNTED  = 3'd5;
	localparam logic [STATUS_W-1:0] ST_NO_CUR   = 3'd6;
	localparam logic [STATUS_W-1:0] ST_DEFERRED = 3'd7;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_RESCHED,
		S_DONE
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture the input transaction
		logic exec;      // create or tick step
		logic resched;   // reschedule step
		logic out_take;  // result handed downstream
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_resched; // exec step asks for a reschedule
		logic is_valid_op;
	} dp_stat_t;

endpackage

// File: src/prrs_datapath.sv
// scheduler tables, selection logic and result register
`timescale 1ns / 1ps
module prrs_datapath #(
	parameter int MAX_THREADS = prrs_pkg::MAX_THREADS_DEF,
	parameter int NUM_LEVELS  = prrs_pkg::NUM_LEVELS_DEF,
	parameter int NUM_CPUS    = prrs_pkg::NUM_CPUS_DEF,
	parameter int SPACE_BITS  = prrs_pkg::SPACE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  prrs_pkg::dp_cmd_t               cmd,
	output prrs_pkg::dp_stat_t              stat,
	input  logic [prrs_pkg::SLICE_W-1:0]    slice_length,
	input  logic [prrs_pkg::OP_W-1:0]       op,
	input  logic [prrs_pkg::PRIO_W-1:0]     priority_req,
	input  logic [prrs_pkg::SPACE_W-1:0]    space_id,
	input  logic [prrs_pkg::CPU_W-1:0]      cpu,
	input  logic                            lock_held,
	output logic [prrs_pkg::STATUS_W-1:0]   status,
	output logic [prrs_pkg::TID_W-1:0]      thread_id,
	output logic                            prev_valid,
	output logic [prrs_pkg::TID_W-1:0]      prev_thread,
	output logic                            space_switch,
	output logic [prrs_pkg::SPACE_W-1:0]    next_space
);
	localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
	localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int NW = $clog2(MAX_THREADS + 1);
	localparam int PW = prrs_pkg::PRIO_W;
	localparam int SW = prrs_pkg::SPACE_W;

	// captured request
	logic [prrs_pkg::OP_W-1:0] op_q;
	logic [PW-1:0]             prio_q;
	logic [SPACE_BITS-1:0]     space_q;
	logic [CW-1:0]             cpu_q;
	logic                      lock_q;

	// state
	logic [NUM_LEVELS-1:0]  ready_mask_q;
	logic [TW-1:0]          ring_head_q [NUM_LEVELS];
	logic [TW-1:0]          ring_tail_q [NUM_LEVELS];
	logic [TW-1:0]          ring_link_q [MAX_THREADS];
	logic [MAX_THREADS-1:0] running_q;
	logic [prrs_pkg::SLICE_W-1:0] slice_left_q [MAX_THREADS];
	logic [SPACE_BITS-1:0]  thread_space_q [MAX_THREADS];
	logic [TW-1:0]          cpu_cur_q [NUM_CPUS];
	logic [NUM_CPUS-1:0]    cpu_cur_valid_q;
	logic [SPACE_BITS-1:0]  cpu_space_q [NUM_CPUS];
	logic [NW-1:0]          total_q;
	logic                   need_resched_q;

	// result register
	logic [prrs_pkg::STATUS_W-1:0] status_q;
	logic [prrs_pkg::TID_W-1:0]    tid_q;
	logic                          pv_q;
	logic [prrs_pkg::TID_W-1:0]    pt_q;
	logic                          ss_q;
	logic [SW-1:0]                 ns_q;

	// cpu number wraps modulo the cpu count, by repeated compare and subtract
	logic [prrs_pkg::CPU_W-1:0] cpu_rem;
	logic [CW-1:0]              cpu_wrap;
	always_comb begin
		cpu_rem = cpu;
		for (int k = 0; k < (1 << prrs_pkg::CPU_W); k++) begin
			if (32'(cpu_rem) >= NUM_CPUS) cpu_rem = cpu_rem - prrs_pkg::CPU_W'(NUM_CPUS);
		end
		cpu_wrap = CW'(cpu_rem);
	end

	// highest ready level
	logic          lvl_found;
	logic [LW-1:0] lvl_sel;
	always_comb begin
		lvl_found = 1'b0;
		lvl_sel = '0;
		for (int l = 0; l < NUM_LEVELS; l++) begin
			if (ready_mask_q[l]) begin
				lvl_found = 1'b1;
				lvl_sel = LW'(l);
			end
		end
	end

	logic [TW-1:0] head, link_head, nxt, prev;
	logic          pv, rotate, stay;
	logic [TW-1:0] cur;
	always_comb begin
		head = ring_head_q[lvl_sel];
		link_head = ring_link_q[head];
		pv = cpu_cur_valid_q[cpu_q];
		prev = cpu_cur_q[cpu_q];
		rotate = pv && (prev == head) && (link_head != head);
		nxt = rotate ? link_head : head;
		stay = pv && (nxt == prev);
		cur = cpu_cur_q[cpu_q];
	end

	logic [TW-1:0] new_id;
	logic          create_ok;
	logic [prrs_pkg::SLICE_W-1:0] dec;
	always_comb begin
		new_id = TW'(total_q);
		create_ok = (32'(total_q) < MAX_THREADS) && (32'(prio_q) < NUM_LEVELS);
		dec = slice_left_q[cur] - 8'd1;
	end

	always_comb begin
		stat.need_resched = need_resched_q;
		stat.is_valid_op = (op == prrs_pkg::OP_CREATE) || (op == prrs_pkg::OP_RESCHED) ||
			(op == prrs_pkg::OP_TICK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_mask_q <= '0;
			running_q <= '0;
			cpu_cur_valid_q <= '0;
			total_q <= '0;
			need_resched_q <= 1'b0;
			for (int c = 0; c < NUM_CPUS; c++) cpu_space_q[c] <= '0;
		end else begin
			if (cmd.load) begin
				op_q <= op;
				prio_q <= priority_req;
				space_q <= SPACE_BITS'(space_id);
				cpu_q <= cpu_wrap;
				lock_q <= lock_held;
				need_resched_q <= 1'b0;
			end
			if (cmd.exec) begin
				ss_q <= 1'b0; pv_q <= 1'b0; pt_q <= '0; ns_q <= '0;
				unique case (op_q)
					prrs_pkg::OP_CREATE: begin
						need_resched_q <= 1'b0;
						if (!create_ok) begin
							status_q <= prrs_pkg::ST_REJECTED;
							tid_q <= '0;
						end else begin
							total_q <= total_q + NW'(1);
							slice_left_q[new_id] <= slice_length;
							thread_space_q[new_id] <= space_q;
							running_q[new_id] <= 1'b0;
							if (!ready_mask_q[LW'(prio_q)]) begin
								ring_head_q[LW'(prio_q)] <= new_id;
								ring_link_q[new_id] <= new_id;
							end else begin
								ring_link_q[ring_tail_q[LW'(prio_q)]] <= new_id;
								ring_link_q[new_id] <= ring_head_q[LW'(prio_q)];
							end
							ring_tail_q[LW'(prio_q)] <= new_id;
							ready_mask_q[LW'(prio_q)] <= 1'b1;
							status_q <= prrs_pkg::ST_CREATED;
							tid_q <= prrs_pkg::TID_W'(new_id);
						end
					end
					prrs_pkg::OP_TICK: begin
						tid_q <= pv ? prrs_pkg::TID_W'(cur) : '0;
						if (!pv) begin
							need_resched_q <= 1'b0;
							status_q <= prrs_pkg::ST_NO_CUR;
						end else if (slice_left_q[cur] != '0 && dec == '0) begin
							slice_left_q[cur] <= slice_length;
							need_resched_q <= !lock_q;
							if (lock_q) status_q <= prrs_pkg::ST_DEFERRED;
						end else begin
							need_resched_q <= 1'b0;
							if (slice_left_q[cur] != '0) slice_left_q[cur] <= dec;
							status_q <= prrs_pkg::ST_COUNTED;
						end
					end
					default: need_resched_q <= 1'b1;
				endcase
			end
			if (cmd.resched) begin
				need_resched_q <= 1'b0;
				if (!lvl_found) begin
					status_q <= prrs_pkg::ST_IDLE;
					tid_q <= pv ? prrs_pkg::TID_W'(prev) : '0;
					pv_q <= 1'b0; pt_q <= '0; ss_q <= 1'b0; ns_q <= '0;
				end else begin
					if (rotate) begin
						ring_head_q[lvl_sel] <= link_head;
						ring_tail_q[lvl_sel] <= head;
					end
					if (stay) begin
						status_q <= prrs_pkg::ST_STAYED;
						tid_q <= prrs_pkg::TID_W'(prev);
						pv_q <= 1'b0; pt_q <= '0; ss_q <= 1'b0; ns_q <= '0;
					end else begin
						cpu_cur_q[cpu_q] <= nxt;
						cpu_cur_valid_q[cpu_q] <= 1'b1;
						if (pv) running_q[prev] <= 1'b0;
						running_q[nxt] <= 1'b1;
						cpu_space_q[cpu_q] <= thread_space_q[nxt];
						status_q <= prrs_pkg::ST_SWITCHED;
						tid_q <= prrs_pkg::TID_W'(nxt);
						pv_q <= pv;
						pt_q <= pv ? prrs_pkg::TID_W'(prev) : '0;
						ss_q <= (thread_space_q[nxt] != cpu_space_q[cpu_q]);
						ns_q <= SW'(thread_space_q[nxt]);
					end
				end
			end
		end
	end

	assign status = status_q;
	assign thread_id = tid_q;
	assign prev_valid = pv_q;
	assign prev_thread = pt_q;
	assign space_switch = ss_q;
	assign next_space = ns_q;

	logic unused_ok;
	assign unused_ok = cmd.out_take | (|running_q);
endmodule

// File: src/prrs_ctrl.sv
// sequencing state machine of the scheduler
`timescale 1ns / 1ps
module prrs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output prrs_pkg::dp_cmd_t    cmd,
	input  prrs_pkg::dp_stat_t   stat
);
	prrs_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= prrs_pkg::S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			prrs_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = stat.is_valid_op ? prrs_pkg::S_EXEC : prrs_pkg::S_IDLE;
				end
			end
			prrs_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
				state_d = prrs_pkg::S_RESCHED;
			end
			prrs_pkg::S_RESCHED: begin
				if (stat.need_resched) cmd.resched = 1'b1;
				state_d = prrs_pkg::S_DONE;
			end
			prrs_pkg::S_DONE: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.out_take = 1'b1;
					state_d = prrs_pkg::S_IDLE;
				end
			end
			default: state_d = prrs_pkg::S_IDLE;
		endcase
	end
endmodule

// File: src/priority_round_robin_scheduler.sv
// top level of the priority round robin thread scheduler
`timescale 1ns / 1ps
// usage:
// - in channel (in_valid/in_ready) carries one operation transaction:
//   op, priority_req, space_id, cpu, lock_held
// - out channel (out_valid/out_ready) returns one result transaction per
//   create, reschedule or tick; op code 3 is consumed with no result
// - cfg channel (cfg_valid/cfg_ready) writes slice_length; write it only
//   while no transaction is in flight
// - sequence: accept, execute, reschedule slot, then out_valid rises in the
//   done state; the next input is accepted on the cycle after the result
//   leaves, so a new transaction is not taken before the last one is through
// - the four-state sequencer handles one transaction at a time; the
//   reschedule step runs after the execute step has updated the tables
// - reset clears the ready mask, thread count, running and current flags,
//   the per-cpu space cache, and loads slice_length with 5
// - a stalled receiver holds the result and in_ready stays low
module priority_round_robin_scheduler #(
	parameter int MAX_THREADS = prrs_pkg::MAX_THREADS_DEF,
	parameter int NUM_LEVELS  = prrs_pkg::NUM_LEVELS_DEF,
	parameter int NUM_CPUS    = prrs_pkg::NUM_CPUS_DEF,
	parameter int SPACE_BITS  = prrs_pkg::SPACE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [prrs_pkg::SLICE_W-1:0]  cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [prrs_pkg::OP_W-1:0]     op,
	input  logic [prrs_pkg::PRIO_W-1:0]   priority_req,
	input  logic [prrs_pkg::SPACE_W-1:0]  space_id,
	input  logic [prrs_pkg::CPU_W-1:0]    cpu,
	input  logic                          lock_held,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [prrs_pkg::STATUS_W-1:0] status,
	output logic [prrs_pkg::TID_W-1:0]    thread_id,
	output logic                          prev_valid,
	output logic [prrs_pkg::TID_W-1:0]    prev_thread,
	output logic                          space_switch,
	output logic [prrs_pkg::SPACE_W-1:0]  next_space
);
	prrs_pkg::dp_cmd_t  cmd;
	prrs_pkg::dp_stat_t stat;
	logic [prrs_pkg::SLICE_W-1:0] slice_len_q;

	// configuration register, always writable
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) slice_len_q <= prrs_pkg::SLICE_RESET;
		else if (cfg_valid) slice_len_q <= cfg_data;
	end

	prrs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd), .stat(stat)
	);

	prrs_datapath #(
		.MAX_THREADS(MAX_THREADS), .NUM_LEVELS(NUM_LEVELS),
		.NUM_CPUS(NUM_CPUS), .SPACE_BITS(SPACE_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.slice_length(slice_len_q),
		.op(op), .priority_req(priority_req), .space_id(space_id),
		.cpu(cpu), .lock_held(lock_held),
		.status(status), .thread_id(thread_id), .prev_valid(prev_valid),
		.prev_thread(prev_thread), .space_switch(space_switch),
		.next_space(next_space)
	);

	// never accept and present a result in the same cycle
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("in_ready with out_valid");
	// no result in the cycle right after an accepted input
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid)
		else $error("result too early");
	// a switch always names a previous thread only when one existed
	a_prev: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !prev_valid) |-> (prev_thread == '0))
		else $error("stray prev_thread");
endmodule
